[hw/rtl/bivariate_gaussian_evaluator_top_assert.svh]
// Assertion macros used by the top-level RTL.
`ifndef BIVARIATE_GAUSSIAN_EVALUATOR_TOP_ASSERT_SVH
`define BIVARIATE_GAUSSIAN_EVALUATOR_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define BGE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define BGE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/bge_pkg.sv]
`default_nettype none

package bge_pkg;

    localparam int unsigned Q_W       = 22;
    localparam logic [30:0] LN2_Q30   = 31'd744261118;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    typedef enum logic [2:0] {
        REG_AMPLITUDE = 3'd0,
        REG_COEF_XX   = 3'd1,
        REG_COEF_XY   = 3'd2,
        REG_COEF_YY   = 3'd3,
        REG_CENTRE_X  = 3'd4,
        REG_CENTRE_Y  = 3'd5
    } bge_reg_t;

    typedef struct packed {
        logic [31:0]        amplitude;
        logic [23:0]        coef_xx;
        logic signed [23:0] coef_xy;
        logic [23:0]        coef_yy;
        logic signed [23:0] centre_x;
        logic signed [23:0] centre_y;
    } bge_cfg_t;

    localparam bge_cfg_t CFG_RESET = '{
        amplitude: 32'h0001_0000,
        coef_xx:   24'h00_8000,
        coef_xy:   24'sh00_0000,
        coef_yy:   24'h00_8000,
        centre_x:  24'sh00_0000,
        centre_y:  24'sh00_0000
    };

    typedef struct packed {
        logic           neg;
        logic           big;
        logic [Q_W-1:0] q;
    } bge_qform_t;

endpackage

`default_nettype wire

[hw/rtl/bivariate_gaussian_evaluator_top.sv]
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  point_x, point_y
// m_*       out        m_tvalid/m_tready  density, saturated
// apb       in         psel/penable       amplitude, coef_xx/xy/yy, centre_x/y
//
// One transaction per cycle sustained while m_tready is high; nine
// register stages (offset, squares, coefficient products, form sum, log2e
// multiply, table index, table read, amplitude multiply, round and shift).
// Reset clears all valid bits and loads the default coefficients.
// A stall holds only the stages that are full; bubbles collapse.
`default_nettype none
`include "bivariate_gaussian_evaluator_top_assert.svh"

module bivariate_gaussian_evaluator_top
    import bge_pkg::*;
#(
    parameter int unsigned EXP_TABLE_DEPTH = 256,
    parameter int unsigned FRAC_BITS       = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // point_x [23:0], point_y [47:24]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // density [31:0]
    output logic             m_tuser    // saturated [0]
);

    bge_cfg_t   cfg_reg, cfg_next;
    logic       cfg_wr;
    logic       mid_valid, mid_ready;
    bge_qform_t mid_q;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        unique case (bge_reg_t'(paddr[4:2]))
            REG_AMPLITUDE: cfg_next.amplitude = pwdata;
            REG_COEF_XX:   cfg_next.coef_xx   = pwdata[23:0];
            REG_COEF_XY:   cfg_next.coef_xy   = pwdata[23:0];
            REG_COEF_YY:   cfg_next.coef_yy   = pwdata[23:0];
            REG_CENTRE_X:  cfg_next.centre_x  = pwdata[23:0];
            REG_CENTRE_Y:  cfg_next.centre_y  = pwdata[23:0];
            default:       cfg_next = cfg_reg;
        endcase
    end

    always_comb
    begin
        unique case (bge_reg_t'(paddr[4:2]))
            REG_AMPLITUDE: prdata = cfg_reg.amplitude;
            REG_COEF_XX:   prdata = {8'd0, cfg_reg.coef_xx};
            REG_COEF_XY:   prdata = {8'd0, cfg_reg.coef_xy};
            REG_COEF_YY:   prdata = {8'd0, cfg_reg.coef_yy};
            REG_CENTRE_X:  prdata = {8'd0, cfg_reg.centre_x};
            REG_CENTRE_Y:  prdata = {8'd0, cfg_reg.centre_y};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_wr)
            cfg_reg <= cfg_next;
    end

    bge_qform u_qform (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[23:0]),
        .in_y      (s_tdata[47:24]),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_q     (mid_q)
    );

    bge_expo #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
        .FRAC_BITS       (FRAC_BITS)
    ) u_expo (
        .clk           (clk),
        .rst_n         (rst_n),
        .amplitude     (cfg_reg.amplitude),
        .in_valid      (mid_valid),
        .in_ready      (mid_ready),
        .in_q          (mid_q),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_density   (m_tdata),
        .out_saturated (m_tuser)
    );

    `BGE_ASSERT_SAME(a_sat_full_scale, clk, rst_n, m_tvalid && m_tuser, m_tdata == 32'hFFFF_FFFF)
    `BGE_ASSERT_SAME(a_stall_from_output, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    `BGE_ASSERT_NEXT(a_amp_write, clk, rst_n, cfg_wr && (paddr[4:2] == REG_AMPLITUDE), cfg_reg.amplitude == $past(pwdata))

endmodule

`default_nettype wire

[hw/rtl/bge_qform.sv]
`default_nettype none

module bge_qform
    import bge_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bge_cfg_t           cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [23:0] in_x,
    input  wire logic signed [23:0] in_y,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bge_qform_t              out_q
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    logic signed [24:0] dx_reg, dy_reg, dx_next, dy_next;
    logic signed [49:0] pxx, pyy, pxy;
    logic [32:0]        sxx_reg, syy_reg, sxx_next, syy_next;
    logic signed [33:0] sxy_reg, sxy_next;
    logic [56:0]        pcxx, pcyy;
    logic signed [57:0] pcxy;
    logic [40:0]        txx_reg, tyy_reg, txx_next, tyy_next;
    logic [41:0]        txy_reg, txy_next;
    logic [42:0]        qsum;
    bge_qform_t         q_reg, q_next;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        dx_next  = {in_x[23], in_x} - {cfg.centre_x[23], cfg.centre_x};
        dy_next  = {in_y[23], in_y} - {cfg.centre_y[23], cfg.centre_y};

        pxx      = dx_reg * dx_reg;
        pyy      = dy_reg * dy_reg;
        pxy      = dx_reg * dy_reg;
        sxx_next = pxx[48:16];
        syy_next = pyy[48:16];
        sxy_next = pxy[49:16];

        pcxx     = cfg.coef_xx * sxx_reg;
        pcyy     = cfg.coef_yy * syy_reg;
        pcxy     = cfg.coef_xy * sxy_reg;
        txx_next = pcxx[56:16];
        tyy_next = pcyy[56:16];
        txy_next = pcxy[57:16];

        qsum       = {txy_reg[41], txy_reg} + {2'b00, txx_reg} + {2'b00, tyy_reg};
        q_next.neg = qsum[42];
        q_next.big = !qsum[42] && (qsum[41:Q_W] != '0);
        q_next.q   = qsum[Q_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (adv2 && v1_reg)
        begin
            sxx_reg <= sxx_next;
            syy_reg <= syy_next;
            sxy_reg <= sxy_next;
        end
        if (adv3 && v2_reg)
        begin
            txx_reg <= txx_next;
            tyy_reg <= tyy_next;
            txy_reg <= txy_next;
        end
        if (adv4 && v3_reg)
        begin
            q_reg <= q_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_q     = q_reg;

endmodule

`default_nettype wire

[hw/rtl/bge_expo.sv]
`default_nettype none

module bge_expo
    import bge_pkg::*;
#(
    parameter int unsigned EXP_TABLE_DEPTH = 256,
    parameter int unsigned FRAC_BITS       = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] amplitude,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire bge_qform_t  in_q,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_density,
    output logic             out_saturated
);

    localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int unsigned FP_W  = 46 + IDX_W + 1;
    localparam int unsigned E_W   = FRAC_BITS + 1;
    localparam int unsigned P_W   = 32 + E_W;
    localparam int unsigned T_W   = Q_W + 31;
    localparam logic [63:0] QD    = 64'(LN2_Q30) / 64'(EXP_TABLE_DEPTH);
    localparam logic [63:0] RD    = 64'(LN2_Q30) % 64'(EXP_TABLE_DEPTH);

    function automatic logic [E_W-1:0] pow2_entry(input logic [IDX_W-1:0] i);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        x    = QD * 64'(i) + (RD * 64'(i)) / EXP_TABLE_DEPTH;
        term = 64'd1 << 30;
        sum  = term;
        term = ((term * x) >> 30) / 64'd1;  sum = sum - term;
        term = ((term * x) >> 30) / 64'd2;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd3;  sum = sum - term;
        term = ((term * x) >> 30) / 64'd4;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd5;  sum = sum - term;
        term = ((term * x) >> 30) / 64'd6;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd7;  sum = sum - term;
        term = ((term * x) >> 30) / 64'd8;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd9;  sum = sum - term;
        term = ((term * x) >> 30) / 64'd10; sum = sum + term;
        term = ((term * x) >> 30) / 64'd11; sum = sum - term;
        term = ((term * x) >> 30) / 64'd12; sum = sum + term;
        term = ((term * x) >> 30) / 64'd13; sum = sum - term;
        term = ((term * x) >> 30) / 64'd14; sum = sum + term;
        term = ((term * x) >> 30) / 64'd15; sum = sum - term;
        term = ((term * x) >> 30) / 64'd16; sum = sum + term;
        rnd  = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return rnd[E_W-1:0];
    endfunction

    logic [E_W-1:0] exp_rom [EXP_TABLE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < EXP_TABLE_DEPTH; gi++)
        begin : g_rom
            assign exp_rom[gi] = pow2_entry(IDX_W'(gi));
        end
    endgenerate

    logic v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic adv5, adv6, adv7, adv8, adv9;

    logic [T_W-1:0]   t_reg, t_next;
    logic             neg5_reg, big5_reg;
    logic [FP_W-1:0]  fprod, fsum;
    logic [IDX_W:0]   rnd_idx;
    logic             wrap;
    logic [6:0]       n_adj;
    logic [7:0]       shift_full;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [5:0]       sh6_reg, sh6_next;
    logic             neg6_reg, big6_reg, big6_next;
    logic [E_W-1:0]   entry_reg, entry_next;
    logic [5:0]       sh7_reg;
    logic             neg7_reg, big7_reg;
    logic [P_W-1:0]   p_reg, p_next;
    logic [5:0]       sh8_reg;
    logic             neg8_reg, big8_reg;
    logic [63:0]      p_round, p_shift;
    logic [31:0]      density_reg, density_next;
    logic             sat_reg;

    assign adv9     = !v9_reg || out_ready;
    assign adv8     = !v8_reg || adv9;
    assign adv7     = !v7_reg || adv8;
    assign adv6     = !v6_reg || adv7;
    assign adv5     = !v5_reg || adv6;
    assign in_ready = adv5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            if (adv5) v5_reg <= in_valid;
            if (adv6) v6_reg <= v5_reg;
            if (adv7) v7_reg <= v6_reg;
            if (adv8) v8_reg <= v7_reg;
            if (adv9) v9_reg <= v8_reg;
        end
    end

    always_comb
    begin
        t_next     = T_W'(in_q.q) * T_W'(LOG2E_Q30);

        fprod      = FP_W'(t_reg[45:0]) * FP_W'(EXP_TABLE_DEPTH);
        fsum       = fprod + (FP_W'(1) << 45);
        rnd_idx    = fsum[FP_W-1:46];
        wrap       = (rnd_idx >= (IDX_W + 1)'(EXP_TABLE_DEPTH));
        idx_next   = wrap ? '0 : rnd_idx[IDX_W-1:0];
        n_adj      = t_reg[T_W-1:46] + 7'(wrap);
        shift_full = 8'(FRAC_BITS) + {1'b0, n_adj};
        big6_next  = big5_reg || (shift_full >= 8'd63);
        sh6_next   = shift_full[5:0];

        entry_next = exp_rom[idx_reg];

        p_next     = P_W'(amplitude) * P_W'(entry_reg);

        p_round    = 64'(p_reg) + (64'd1 << (sh8_reg - 6'd1));
        p_shift    = p_round >> sh8_reg;
        if (neg8_reg)
            density_next = '1;
        else if (big8_reg)
            density_next = '0;
        else if (p_shift[63:32] != '0)
            density_next = '1;
        else
            density_next = p_shift[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv5 && in_valid)
        begin
            t_reg    <= t_next;
            neg5_reg <= in_q.neg;
            big5_reg <= in_q.big;
        end
        if (adv6 && v5_reg)
        begin
            idx_reg  <= idx_next;
            sh6_reg  <= sh6_next;
            neg6_reg <= neg5_reg;
            big6_reg <= big6_next;
        end
        if (adv7 && v6_reg)
        begin
            entry_reg <= entry_next;
            sh7_reg   <= sh6_reg;
            neg7_reg  <= neg6_reg;
            big7_reg  <= big6_reg;
        end
        if (adv8 && v7_reg)
        begin
            p_reg    <= p_next;
            sh8_reg  <= sh7_reg;
            neg8_reg <= neg7_reg;
            big8_reg <= big7_reg;
        end
        if (adv9 && v8_reg)
        begin
            density_reg <= density_next;
            sat_reg     <= neg8_reg;
        end
    end

    assign out_valid     = v9_reg;
    assign out_density   = density_reg;
    assign out_saturated = sat_reg;

endmodule

`default_nettype wire
